// ===== hw/rtl/qwd_pkg.sv =====
// Shared types, constants and helpers of the QuickProp weight change unit.
package qwd_pkg;

	// Q16.16 one
	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	// Restoring divider: one quotient bit per cell
	localparam int NUM_W = 63;
	localparam int DEN_W = 33;
	localparam int DIV_STEPS = NUM_W;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LR     = 2'd0,
		CFG_LR_OUT = 2'd1,
		CFG_MU     = 2'd2
	} cfg_idx_t;

	// Word handed from cell to cell along the divider chain
	typedef struct packed {
		logic [NUM_W-1:0]   nq;      // numerator bits going out, quotient bits coming in
		logic [DEN_W-1:0]   rem;     // partial remainder
		logic [DEN_W-1:0]   den;     // divisor magnitude
		logic signed [63:0] base;    // gradient and growth terms already summed
		logic               neg;     // secant quotient is negative
		logic               use_sec; // secant term is added
	} div_word_t;

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/qwd_front.sv =====
// Front pipeline: gradients, products, ratio test and divider set-up.
module qwd_front import qwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [31:0] prev_change,
	input  logic signed [31:0] act_now,
	input  logic signed [31:0] act_prev,
	input  logic signed [31:0] delta_now,
	input  logic signed [31:0] delta_before,
	input  logic               is_output_layer,
	input  logic               is_bias,
	input  logic [30:0]        lr_hid,
	input  logic [30:0]        lr_out,
	input  logic [30:0]        mu,
	output logic               vld_s4,
	output div_word_t          word_s4
);

	// stage 1: activation products and growth product
	logic               vld_s1;
	logic signed [63:0] p_now_s1, p_prev_s1, pm_s1;
	logic signed [31:0] d_s1;
	logic [30:0]        lr_s1, mu_s1;
	logic signed [31:0] a_now_c, a_prev_c, mu_sc;

	always_comb begin
		a_now_c  = is_bias ? Q_ONE : act_now;
		a_prev_c = is_bias ? Q_ONE : act_prev;
		mu_sc    = $signed({1'b0, mu});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_now_s1  <= a_now_c * delta_now;
			p_prev_s1 <= a_prev_c * delta_before;
			pm_s1     <= mu_sc * prev_change;
			d_s1      <= prev_change;
			lr_s1     <= is_output_layer ? lr_out : lr_hid;
			mu_s1     <= mu;
		end
	end

	// stage 2: saturated gradients, growth term
	logic               vld_s2;
	logic signed [31:0] g_s2, gp_s2, d_s2;
	logic signed [63:0] growth_s2;
	logic [30:0]        lr_s2, mu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2      <= sat32(p_now_s1 >>> 16);
			gp_s2     <= sat32(p_prev_s1 >>> 16);
			growth_s2 <= pm_s1 >>> 16;
			d_s2      <= d_s1;
			lr_s2     <= lr_s1;
			mu_s2     <= mu_s1;
		end
	end

	// stage 3: step, ratio test and secant products
	logic               vld_s3;
	logic signed [63:0] gl_s3, gd_s3, growth_s3;
	logic signed [64:0] lhs_s3, rhs_s3;
	logic signed [32:0] diff_s3;
	logic signed [31:0] g_s3, d_s3;
	logic [31:0]        mu_one_c;

	assign mu_one_c = 32'(Q_ONE) + {1'b0, mu_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gl_s3     <= g_s2 * $signed({1'b0, lr_s2});
			lhs_s3    <= g_s2 * $signed({1'b0, mu_one_c});
			rhs_s3    <= $signed({1'b0, mu_s2}) * gp_s2;
			gd_s3     <= g_s2 * d_s2;
			diff_s3   <= 33'(gp_s2) - 33'(g_s2);
			growth_s3 <= growth_s2;
			g_s3      <= g_s2;
			d_s3      <= d_s2;
		end
	end

	// stage 4: select terms, set up the division
	logic signed [63:0] step_c, neg_gl_c;
	logic               dz_c, dpos_c, add_step_c, capped_c, use_grow_c;
	div_word_t          word_c;

	always_comb begin
		neg_gl_c   = -gl_s3;
		step_c     = neg_gl_c >>> 16;
		dz_c       = (d_s3 == 32'sd0);
		dpos_c     = !dz_c && !d_s3[31];
		add_step_c = dz_c || (dpos_c && (g_s3 > 32'sd0)) || (!dpos_c && g_s3[31]);
		capped_c   = dpos_c ? (lhs_s3 > rhs_s3) : (lhs_s3 < rhs_s3);
		use_grow_c = capped_c || (diff_s3 == 33'sd0);
		word_c.base = (add_step_c ? step_c : 64'sd0)
			+ ((!dz_c && use_grow_c) ? growth_s3 : 64'sd0);
		word_c.use_sec = !dz_c && !use_grow_c;
		word_c.neg     = gd_s3[63] ^ diff_s3[32];
		word_c.nq      = gd_s3[63] ? NUM_W'(-gd_s3) : NUM_W'(gd_s3);
		word_c.den     = diff_s3[32] ? DEN_W'(-diff_s3) : DEN_W'(diff_s3);
		word_c.rem     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s4 <= word_c;
		end
	end

endmodule

// ===== hw/rtl/qwd_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit.
module qwd_div_cell import qwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_i,
	input  div_word_t word_i,
	output logic      vld_q,
	output div_word_t word_q
);

	logic [DEN_W:0]   shifted_c;
	logic             ge_c;
	div_word_t        word_c;

	// shift in next numerator bit, subtract divisor when it fits
	always_comb begin
		shifted_c = {word_i.rem, word_i.nq[NUM_W-1]};
		ge_c      = shifted_c >= {1'b0, word_i.den};
		word_c    = word_i;
		word_c.rem = ge_c ? DEN_W'(shifted_c - {1'b0, word_i.den}) : shifted_c[DEN_W-1:0];
		word_c.nq  = {word_i.nq[NUM_W-2:0], ge_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_c;
		end
	end

endmodule

// ===== hw/rtl/quickprop_weight_delta_unit.sv =====
// QuickProp weight change unit: top level with config registers, divider chain and output.
// Takes one request per clock and returns one weight_change per request, in order,
// through 68 register stages: four front stages (gradients, products, ratio test),
// 63 divider cells that each resolve one bit of the secant quotient, and the output
// register that adds the terms and saturates. The whole pipeline holds while a result
// waits under out_stall; in_stall is raised only then. Configuration writes are taken every
// cycle (cfg_ready is always high); indexes beyond the register list are ignored.
module quickprop_weight_delta_unit import qwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] prev_change,
	input  logic signed [31:0] act_now,
	input  logic signed [31:0] act_prev,
	input  logic signed [31:0] delta_now,
	input  logic signed [31:0] delta_before,
	input  logic               is_output_layer,
	input  logic               is_bias,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] weight_change,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [30:0] lr_q, lr_out_q, mu_q;
	logic        en;
	logic        out_vld_q;
	logic signed [31:0] wc_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= 31'd6554;
			lr_out_q <= 31'd6554;
			mu_q     <= 31'd114688;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LR:     lr_q     <= cfg_data[30:0];
				CFG_LR_OUT: lr_out_q <= cfg_data[30:0];
				CFG_MU:     mu_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless a result is held
	assign en       = !out_vld_q || !out_stall;
	assign in_stall = !en;

	logic      vld_c [0:DIV_STEPS];
	div_word_t word_c [0:DIV_STEPS];

	qwd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_vld          (in_valid),
		.prev_change     (prev_change),
		.act_now         (act_now),
		.act_prev        (act_prev),
		.delta_now       (delta_now),
		.delta_before    (delta_before),
		.is_output_layer (is_output_layer),
		.is_bias         (is_bias),
		.lr_hid          (lr_q),
		.lr_out          (lr_out_q),
		.mu              (mu_q),
		.vld_s4          (vld_c[0]),
		.word_s4         (word_c[0])
	);

	// divider chain
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		qwd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[i]),
			.word_i (word_c[i]),
			.vld_q  (vld_c[i+1]),
			.word_q (word_c[i+1])
		);
	end

	// final sum and saturation
	logic signed [63:0] quo_c, sum_c;
	div_word_t          last_c;

	always_comb begin
		last_c = word_c[DIV_STEPS];
		quo_c  = last_c.neg ? -$signed({1'b0, last_c.nq}) : $signed({1'b0, last_c.nq});
		sum_c  = last_c.base + (last_c.use_sec ? quo_c : 64'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_c[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wc_q <= sat32(sum_c);
		end
	end

	assign out_valid     = out_vld_q;
	assign weight_change = wc_q;

endmodule

// ===== hw/rtl/qwd_checker.sv =====
// Port-level checks of the QuickProp weight change unit, bound to the top level.
module qwd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] weight_change,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// held result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight_change))
		else $error("held result changed");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// no stall when the output side is free
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// config requests never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config request not taken");

endmodule

bind quickprop_weight_delta_unit qwd_checker u_qwd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.weight_change (weight_change),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
